@@ hw/rtl/touch_sample_average_calibrate_top_defines.svh @@
// Assertion macros shared by the touch averaging and calibration checkers.
`ifndef TOUCH_SAMPLE_AVERAGE_CALIBRATE_TOP_DEFINES_SVH
`define TOUCH_SAMPLE_AVERAGE_CALIBRATE_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TSAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define TSAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tsac_pkg.sv @@
// Shared constants, register codes and unit status type for the touch block.
package tsac_pkg;

   // Field and datapath widths
   localparam int RAW_W   = 12;
   localparam int COORD_W = 16;
   localparam int MAG_W   = 13;
   localparam int PROD_W  = MAG_W + RAW_W;
   localparam int PRES_W  = 10;
   localparam int STAMP_W = 16;

   // Averaging depth and sample counter width
   localparam int AVG_SAMPLES = 3;
   localparam int CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;

   // Fixed values
   localparam logic signed [COORD_W-1:0] INVERT_BASE   = 16'sd4000;
   localparam logic [PRES_W-1:0]         PRESSURE_DOWN = 10'd1000;
   localparam logic [PRES_W-1:0]         PRESSURE_UP   = 10'd0;

   // Register indexes
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_CAL_EN  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_REVERSE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAX_X   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MIN_X   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_Y   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MIN_Y   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_RES_X   = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_RES_Y   = 3'd7;

   // Status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

@@ hw/rtl/touch_sample_average_calibrate_top.sv @@
// Touch sample averaging and linear calibration, top level.
//
// Each request word is one panel event. Coordinates are inverted as 4000 minus
// raw; while the pen is down, every third sample yields the averaged position
// with pressure 1000, and a pen release after a press yields one word with
// pressure 0 and the release coordinates. With calibration enabled each axis is
// mapped from its raw min/max window onto its resolution (a zero window gives
// 0). An event that yields no word leaves the block idle, so the next event is
// accepted in the following cycle. An event that yields a word keeps the block
// busy while each axis in turn passes through the averaging division, when an
// average is formed, and the calibration multiply and divide, when calibration
// is on, plus any wait for the output register to free up; the work is done by
// the bit-serial divider and the shift-add multiplier, one shared unit of each
// serving both axes. A finished word waits in the output register while the
// next event is taken.
module touch_sample_average_calibrate_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // sample_x[11:0], sample_y[23:12], tick_stamp[39:24]
   input  logic [1:0]  req_tuser,  // pen_on[0], pen_off[1]
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // pressure[9:0], pos_x[25:10], pos_y[41:26],
                                   // stamp[57:42], zero[63:58]
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int RW = tsac_pkg::RAW_W;
   localparam int CW = tsac_pkg::COORD_W;
   localparam int PW = tsac_pkg::PROD_W;
   localparam int MW = tsac_pkg::MAG_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_AXIS, ST_AVG, ST_CAL, ST_MUL, ST_CDIV, ST_NEXT, ST_EMIT
   } state_type;

   // Configuration registers
   logic          cal_en_ff;
   logic [1:0]    reverse_ff;
   logic [RW-1:0] max_x_ff, min_x_ff, max_y_ff, min_y_ff, res_x_ff, res_y_ff;

   // Accumulation state
   logic signed [CW-1:0]         sum_x_ff, sum_y_ff;
   logic [tsac_pkg::CNT_W-1:0]   count_ff;
   logic                         pen_down_ff;

   // Work registers
   state_type                    state_ff;
   logic                         axis_ff;
   logic                         avg_ff;
   logic                         neg_ff;
   logic signed [CW-1:0]         work_x_ff, work_y_ff;
   logic [tsac_pkg::PRES_W-1:0]  pres_ff;
   logic [tsac_pkg::STAMP_W-1:0] stamp_ff;

   // Arithmetic unit control
   logic          mul_start_ff, div_start_ff;
   logic [MW-1:0] mul_a_ff;
   logic [RW-1:0] mul_b_ff;
   logic [PW-1:0] div_n_ff;
   logic [RW-1:0] div_d_ff;
   logic [PW-1:0] mul_p, div_q;
   tsac_pkg::unit_stat_type mul_stat, div_stat;

   // Output register
   logic          rsp_valid_ff;
   logic [63:0]   rsp_data_ff;

   // Input unpacking
   logic                 pen_on, pen_off, req_fire, csr_wr;
   logic [RW-1:0]        sample_x, sample_y;
   logic signed [CW-1:0] inv_x_in, inv_y_in, sum_x_in, sum_y_in;
   logic                 avg_full_in;

   // Axis datapath
   logic signed [CW-1:0] v_cur, num_in, span_in, num_mag_in, span_mag_in, v_mag_in;
   logic [RW-1:0]        hi_cur, lo_cur, res_cur;
   logic                 rev_cur;
   logic [PW-1:0]        q_signed_in;

   assign pen_on   = req_tuser[0];
   assign pen_off  = req_tuser[1];
   assign sample_x = req_tdata[11:0];
   assign sample_y = req_tdata[23:12];
   assign req_fire = req_tvalid && req_tready;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign inv_x_in    = tsac_pkg::INVERT_BASE - CW'(sample_x);
   assign inv_y_in    = tsac_pkg::INVERT_BASE - CW'(sample_y);
   assign sum_x_in    = sum_x_ff + inv_x_in;
   assign sum_y_in    = sum_y_ff + inv_y_in;
   assign avg_full_in = count_ff == tsac_pkg::CNT_W'(tsac_pkg::AVG_SAMPLES - 1);

   // Select the axis under work
   assign v_cur   = axis_ff ? work_y_ff : work_x_ff;
   assign hi_cur  = axis_ff ? max_y_ff : max_x_ff;
   assign lo_cur  = axis_ff ? min_y_ff : min_x_ff;
   assign res_cur = axis_ff ? res_y_ff : res_x_ff;
   assign rev_cur = axis_ff ? reverse_ff[1] : reverse_ff[0];

   assign span_in     = CW'(hi_cur) - CW'(lo_cur);
   assign num_in      = rev_cur ? (CW'(hi_cur) - v_cur) : (v_cur - CW'(lo_cur));
   assign num_mag_in  = num_in[CW-1] ? -num_in : num_in;
   assign span_mag_in = span_in[CW-1] ? -span_in : span_in;
   assign v_mag_in    = v_cur[CW-1] ? -v_cur : v_cur;
   assign q_signed_in = neg_ff ? -div_q : div_q;

   tsac_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mcand   (mul_a_ff),
      .mplier  (mul_b_ff),
      .product (mul_p),
      .stat    (mul_stat)
   );

   tsac_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .quotient (div_q),
      .stat     (div_stat)
   );

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_en_ff  <= 1'b0;
         reverse_ff <= 2'd0;
         max_x_ff   <= 12'd4000;
         min_x_ff   <= 12'd200;
         max_y_ff   <= 12'd4000;
         min_y_ff   <= 12'd200;
         res_x_ff   <= 12'd240;
         res_y_ff   <= 12'd320;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            tsac_pkg::REG_CAL_EN:  cal_en_ff  <= csr_pwdata[0];
            tsac_pkg::REG_REVERSE: reverse_ff <= csr_pwdata[1:0];
            tsac_pkg::REG_MAX_X:   max_x_ff   <= csr_pwdata[RW-1:0];
            tsac_pkg::REG_MIN_X:   min_x_ff   <= csr_pwdata[RW-1:0];
            tsac_pkg::REG_MAX_Y:   max_y_ff   <= csr_pwdata[RW-1:0];
            tsac_pkg::REG_MIN_Y:   min_y_ff   <= csr_pwdata[RW-1:0];
            tsac_pkg::REG_RES_X:   res_x_ff   <= csr_pwdata[RW-1:0];
            tsac_pkg::REG_RES_Y:   res_y_ff   <= csr_pwdata[RW-1:0];
         endcase
      end
   end

   // Read back configuration registers
   always_comb begin
      unique case (csr_paddr[4:2])
         tsac_pkg::REG_CAL_EN:  csr_prdata = {31'd0, cal_en_ff};
         tsac_pkg::REG_REVERSE: csr_prdata = {30'd0, reverse_ff};
         tsac_pkg::REG_MAX_X:   csr_prdata = 32'(max_x_ff);
         tsac_pkg::REG_MIN_X:   csr_prdata = 32'(min_x_ff);
         tsac_pkg::REG_MAX_Y:   csr_prdata = 32'(max_y_ff);
         tsac_pkg::REG_MIN_Y:   csr_prdata = 32'(min_y_ff);
         tsac_pkg::REG_RES_X:   csr_prdata = 32'(res_x_ff);
         tsac_pkg::REG_RES_Y:   csr_prdata = 32'(res_y_ff);
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = state_ff == ST_IDLE;

   // Sequence the events and both axes through the shared units
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         count_ff     <= '0;
         pen_down_ff  <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               axis_ff  <= 1'b0;
               stamp_ff <= req_tdata[39:24];
               if (req_fire && pen_on) begin
                  pen_down_ff <= 1'b1;
                  if (avg_full_in) begin
                     sum_x_ff  <= '0;
                     sum_y_ff  <= '0;
                     count_ff  <= '0;
                     work_x_ff <= sum_x_in;
                     work_y_ff <= sum_y_in;
                     avg_ff    <= 1'b1;
                     pres_ff   <= tsac_pkg::PRESSURE_DOWN;
                     state_ff  <= ST_AXIS;
                  end else begin
                     sum_x_ff <= sum_x_in;
                     sum_y_ff <= sum_y_in;
                     count_ff <= count_ff + 1'b1;
                  end
               end else if (req_fire && pen_off && pen_down_ff) begin
                  pen_down_ff <= 1'b0;
                  sum_x_ff    <= '0;
                  sum_y_ff    <= '0;
                  count_ff    <= '0;
                  work_x_ff   <= inv_x_in;
                  work_y_ff   <= inv_y_in;
                  avg_ff      <= 1'b0;
                  pres_ff     <= tsac_pkg::PRESSURE_UP;
                  state_ff    <= ST_AXIS;
               end
            end
            ST_AXIS: begin
               if (avg_ff) begin
                  neg_ff       <= v_cur[CW-1];
                  div_n_ff     <= PW'(v_mag_in);
                  div_d_ff     <= RW'(tsac_pkg::AVG_SAMPLES);
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_AVG;
               end else begin
                  state_ff <= ST_CAL;
               end
            end
            ST_AVG: begin
               if (div_stat.done) begin
                  if (axis_ff) begin
                     work_y_ff <= q_signed_in[CW-1:0];
                  end else begin
                     work_x_ff <= q_signed_in[CW-1:0];
                  end
                  state_ff <= ST_CAL;
               end
            end
            ST_CAL: begin
               if (!cal_en_ff) begin
                  state_ff <= ST_NEXT;
               end else if (span_in == '0) begin
                  if (axis_ff) begin
                     work_y_ff <= '0;
                  end else begin
                     work_x_ff <= '0;
                  end
                  state_ff <= ST_NEXT;
               end else begin
                  neg_ff       <= num_in[CW-1] ^ span_in[CW-1];
                  mul_a_ff     <= num_mag_in[MW-1:0];
                  mul_b_ff     <= res_cur;
                  div_d_ff     <= span_mag_in[RW-1:0];
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mul_stat.done) begin
                  div_n_ff     <= mul_p;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_CDIV;
               end
            end
            ST_CDIV: begin
               if (div_stat.done) begin
                  if (axis_ff) begin
                     work_y_ff <= q_signed_in[CW-1:0];
                  end else begin
                     work_x_ff <= q_signed_in[CW-1:0];
                  end
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (axis_ff) begin
                  state_ff <= ST_EMIT;
               end else begin
                  axis_ff  <= 1'b1;
                  state_ff <= ST_AXIS;
               end
            end
            ST_EMIT: begin
               // Load the output register once it is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'd0, stamp_ff, work_y_ff, work_x_ff, pres_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hw/rtl/tsac_serial_mul.sv @@
// Shift-add multiplier: one multiplier bit per cycle, unsigned magnitudes.
module tsac_serial_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tsac_pkg::MAG_W-1:0]  mcand,
   input  logic [tsac_pkg::RAW_W-1:0]  mplier,
   output logic [tsac_pkg::PROD_W-1:0] product,
   output tsac_pkg::unit_stat_type     stat
);

   localparam int CNT_W = $clog2(tsac_pkg::RAW_W + 1);

   logic [tsac_pkg::PROD_W-1:0] prod_ff;
   logic [tsac_pkg::MAG_W-1:0]  mcand_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [tsac_pkg::MAG_W:0]    sum_in;

   // Add the multiplicand into the high half when the low bit is set
   assign sum_in = {1'b0, prod_ff[tsac_pkg::PROD_W-1:tsac_pkg::RAW_W]} +
                   (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   // Shift one bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= CNT_W'(tsac_pkg::RAW_W);
            prod_ff  <= {{tsac_pkg::MAG_W{1'b0}}, mplier};
            mcand_ff <= mcand;
         end else if (busy_ff) begin
            prod_ff <= {sum_in, prod_ff[tsac_pkg::RAW_W-1:1]};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign product   = prod_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hw/rtl/tsac_serial_div.sv @@
// Restoring divider: one quotient bit per cycle, unsigned magnitudes.
module tsac_serial_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tsac_pkg::PROD_W-1:0] dividend,
   input  logic [tsac_pkg::RAW_W-1:0]  divisor,
   output logic [tsac_pkg::PROD_W-1:0] quotient,
   output tsac_pkg::unit_stat_type     stat
);

   localparam int CNT_W = $clog2(tsac_pkg::PROD_W + 1);

   logic [tsac_pkg::PROD_W-1:0] quot_ff;
   logic [tsac_pkg::RAW_W-1:0]  rem_ff;
   logic [tsac_pkg::RAW_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [tsac_pkg::RAW_W:0]    trial_in;
   logic [tsac_pkg::RAW_W:0]    diff_in;
   logic                        fits_in;

   // Bring down the next dividend bit and try the subtraction
   assign trial_in = {rem_ff, quot_ff[tsac_pkg::PROD_W-1]};
   assign fits_in  = trial_in >= {1'b0, dvs_ff};
   assign diff_in  = trial_in - {1'b0, dvs_ff};

   // Develop one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(tsac_pkg::PROD_W);
            quot_ff <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= fits_in ? diff_in[tsac_pkg::RAW_W-1:0]
                               : trial_in[tsac_pkg::RAW_W-1:0];
            quot_ff <= {quot_ff[tsac_pkg::PROD_W-2:0], fits_in};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hw/rtl/tsac_checker.sv @@
// Port checker for the touch averaging and calibration block, with its bind.
`include "touch_sample_average_calibrate_top_defines.svh"

module tsac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // A stalled response word holds
   `TSAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // Pressure is either pen-down or pen-up
   `TSAC_ASSERT_SAME(a_pressure, clock, reset, rsp_tvalid, rsp_tdata[9:0] == 10'd1000 || rsp_tdata[9:0] == 10'd0, "pressure out of range")

   // A response never appears in the cycle right after a request is taken
   `TSAC_ASSERT_NEXT(a_latency, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "response appeared too early")

endmodule

bind touch_sample_average_calibrate_top tsac_checker u_tsac_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ verif/tb.sv @@
// Self-checking testbench for the touch sample averaging and calibration block.

typedef struct {
   logic              cal_en;
   logic [1:0]        rev;
   logic [11:0]       max_x;
   logic [11:0]       min_x;
   logic [11:0]       max_y;
   logic [11:0]       min_y;
   logic [11:0]       res_x;
   logic [11:0]       res_y;
} cal_settings_type;

typedef struct {
   logic [9:0]        pressure;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [15:0]       stamp;
} touch_word_type;

// Tracks pen state and calibration, and holds the touch words still to come.
class touch_scoreboard;
   logic        cal_en;
   logic [1:0]  rev;
   logic [11:0] max_x, min_x, max_y, min_y, res_x, res_y;
   int          acc_x, acc_y, acc_count;
   bit          pen_down;
   touch_word_type touch_q[$];
   int          fail_count;

   function new();
      cal_en = 1'b0;
      rev = 2'd0;
      max_x = 12'd4000;
      min_x = 12'd200;
      max_y = 12'd4000;
      min_y = 12'd200;
      res_x = 12'd240;
      res_y = 12'd320;
      acc_x = 0;
      acc_y = 0;
      acc_count = 0;
      pen_down = 1'b0;
      fail_count = 0;
   endfunction

   // Keep only the bits each register holds.
   function void set_reg(logic [2:0] idx, logic [31:0] wdata);
      case (idx)
         tsac_pkg::REG_CAL_EN:  cal_en = wdata[0];
         tsac_pkg::REG_REVERSE: rev = wdata[1:0];
         tsac_pkg::REG_MAX_X:   max_x = wdata[11:0];
         tsac_pkg::REG_MIN_X:   min_x = wdata[11:0];
         tsac_pkg::REG_MAX_Y:   max_y = wdata[11:0];
         tsac_pkg::REG_MIN_Y:   min_y = wdata[11:0];
         tsac_pkg::REG_RES_X:   res_x = wdata[11:0];
         tsac_pkg::REG_RES_Y:   res_y = wdata[11:0];
         default: ;
      endcase
   endfunction

   // Linear map of one axis; a zero-width window gives 0.
   function int map_axis(int v, int hi, int lo, int res, bit flip);
      int span;
      int num;
      span = hi - lo;
      if (span == 0) return 0;
      num = flip ? (hi - v) : (v - lo);
      return (num * res) / span;
   endfunction

   function void push_word(logic [9:0] pres, int x, int y, logic [15:0] stamp);
      touch_word_type w;
      if (cal_en) begin
         x = map_axis(x, int'(max_x), int'(min_x), int'(res_x), rev[0]);
         y = map_axis(y, int'(max_y), int'(min_y), int'(res_y), rev[1]);
      end
      w.pressure = pres;
      w.pos_x = x[15:0];
      w.pos_y = y[15:0];
      w.stamp = stamp;
      touch_q.push_back(w);
   endfunction

   // Advance pen state for one accepted request word.
   function void note_word(bit on, bit off, logic [11:0] sx, logic [11:0] sy,
                           logic [15:0] stamp);
      int ix;
      int iy;
      ix = int'(tsac_pkg::INVERT_BASE) - int'(sx);
      iy = int'(tsac_pkg::INVERT_BASE) - int'(sy);
      if (on) begin
         pen_down = 1'b1;
         acc_x += ix;
         acc_y += iy;
         acc_count++;
         if (acc_count == tsac_pkg::AVG_SAMPLES) begin
            push_word(tsac_pkg::PRESSURE_DOWN, acc_x / tsac_pkg::AVG_SAMPLES,
                      acc_y / tsac_pkg::AVG_SAMPLES, stamp);
            acc_x = 0;
            acc_y = 0;
            acc_count = 0;
         end
      end else if (off && pen_down) begin
         pen_down = 1'b0;
         acc_x = 0;
         acc_y = 0;
         acc_count = 0;
         push_word(tsac_pkg::PRESSURE_UP, ix, iy, stamp);
      end
   endfunction

   // Compare one response word with the oldest expected touch word.
   function void check_word(logic [63:0] data);
      touch_word_type want;
      if (touch_q.size() == 0) begin
         $error("response word %h arrived with none expected", data);
         fail_count++;
         return;
      end
      want = touch_q.pop_front();
      if (data[9:0] !== want.pressure) begin
         $error("pressure: expected %0d, actual %0d", want.pressure, data[9:0]);
         fail_count++;
      end
      if (data[25:10] !== want.pos_x) begin
         $error("pos_x: expected %0d, actual %0d", want.pos_x, $signed(data[25:10]));
         fail_count++;
      end
      if (data[41:26] !== want.pos_y) begin
         $error("pos_y: expected %0d, actual %0d", want.pos_y, $signed(data[41:26]));
         fail_count++;
      end
      if (data[57:42] !== want.stamp) begin
         $error("stamp: expected %0d, actual %0d", want.stamp, data[57:42]);
         fail_count++;
      end
   endfunction

   function int pending();
      return touch_q.size();
   endfunction
endclass

module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   touch_scoreboard  touch_sb = new;
   cal_settings_type settings;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               holdoff_request = 0;
   int               items_sent = 0;

   touch_sample_average_calibrate_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #15_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: check each accepted word, stall at random or for a long hold-off.
   initial begin
      int holdoff_left;
      holdoff_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) touch_sb.check_word(rsp_tdata);
         if (holdoff_request > 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Write all eight registers back to back, with junk above each field.
   task automatic load_settings(input cal_settings_type s);
      logic [11:0] value [8];
      logic [31:0] mask;
      logic [31:0] wdata;
      value[tsac_pkg::REG_CAL_EN]  = {11'd0, s.cal_en};
      value[tsac_pkg::REG_REVERSE] = {10'd0, s.rev};
      value[tsac_pkg::REG_MAX_X]   = s.max_x;
      value[tsac_pkg::REG_MIN_X]   = s.min_x;
      value[tsac_pkg::REG_MAX_Y]   = s.max_y;
      value[tsac_pkg::REG_MIN_Y]   = s.min_y;
      value[tsac_pkg::REG_RES_X]   = s.res_x;
      value[tsac_pkg::REG_RES_Y]   = s.res_y;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) == tsac_pkg::REG_CAL_EN) mask = 32'h1;
         else if (3'(i) == tsac_pkg::REG_REVERSE) mask = 32'h3;
         else mask = 32'hFFF;
         wdata = ($urandom & ~mask) | {20'd0, value[i]};
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {3'(i), 2'b00};
         csr_pwdata <= wdata;
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         touch_sb.set_reg(3'(i), wdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Offer one request word after a random gap; return once it is taken.
   task automatic send_word(input bit on, input bit off, input logic [11:0] sx,
                            input logic [11:0] sy, input logic [15:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {stamp, sy, sx};
      req_tuser <= {off, on};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      touch_sb.note_word(on, off, sx, sy, stamp);
      if (on || off) items_sent++;
   endtask

   // Drop valid, wait for every expected word, then let the block settle.
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (touch_sb.pending() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Raw reading biased toward the ends of the range.
   function automatic logic [11:0] rand_raw();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 12'd4095 : 12'd0;
      return 12'($urandom_range(4095));
   endfunction

   // One pen stroke: presses, an optional release, and some noise.
   task automatic send_stroke();
      int presses;
      presses = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(8, 1);
      for (int i = 0; i < presses; i++) begin
         if ($urandom_range(19) == 0)
            send_word(1'b0, 1'b0, rand_raw(), rand_raw(), 16'($urandom));
         send_word(1'b1, $urandom_range(7) == 0, rand_raw(), rand_raw(), 16'($urandom));
      end
      if ($urandom_range(9) != 0)
         send_word(1'b0, 1'b1, rand_raw(), rand_raw(), 16'($urandom));
      // second release; the pen is already up only if the release above was sent
      if ($urandom_range(7) == 0)
         send_word(1'b0, 1'b1, rand_raw(), rand_raw(), 16'($urandom));
   endtask

   initial begin
      bit paused;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words with calibration on over the default window
      settings = '{1'b1, 2'd0, 12'd4000, 12'd200, 12'd4000, 12'd200, 12'd240, 12'd320};
      load_settings(settings);
      send_idle_pct = 35;
      recv_idle_pct = 77;
      send_word(1'b0, 1'b1, 12'd123, 12'd456, 16'd1);       // release, pen never down
      send_word(1'b0, 1'b0, 12'd4095, 12'd4095, 16'hFFFF);  // no flag
      send_word(1'b1, 1'b0, 12'd0, 12'd0, 16'd0);
      send_word(1'b1, 1'b0, 12'd4095, 12'd4095, 16'hFFFF);
      send_word(1'b0, 1'b1, 12'd0, 12'd4095, 16'd2);        // release mid-average
      send_word(1'b0, 1'b1, 12'd7, 12'd9, 16'd3);           // second release
      send_word(1'b1, 1'b1, 12'd4095, 12'd0, 16'd4);        // both flags
      send_word(1'b0, 1'b0, 12'd0, 12'd0, 16'd5);
      send_word(1'b1, 1'b0, 12'd4095, 12'd4095, 16'd6);
      send_word(1'b1, 1'b0, 12'd4095, 12'd4095, 16'd7);     // negative average
      send_word(1'b1, 1'b0, 12'd0, 12'd0, 16'd8);
      send_word(1'b1, 1'b0, 12'd1, 12'd2, 16'd9);
      send_word(1'b1, 1'b0, 12'd4095, 12'd4094, 16'd10);
      send_word(1'b0, 1'b1, 12'd4095, 12'd0, 16'hFFFF);
      send_word(1'b1, 1'b0, 12'd0, 12'd0, 16'd11);
      send_word(1'b1, 1'b0, 12'd0, 12'd0, 16'd12);
      send_word(1'b1, 1'b0, 12'd0, 12'd0, 16'd13);
      send_word(1'b0, 1'b1, 12'd0, 12'd0, 16'd14);
      send_word(1'b1, 1'b0, 12'd2048, 12'd1024, 16'h8000);
      send_word(1'b0, 1'b1, 12'd2047, 12'd3071, 16'h7FFF);

      // Random phases, each with its own calibration and idling
      for (int phase = 0; phase < 6; phase++) begin
         drain(150);
         case (phase)
            0: settings = '{1'b0, 2'd0, 12'd4000, 12'd200, 12'd4000, 12'd200,
                            12'd240, 12'd320};
            1: settings = '{1'b1, 2'd3, 12'd4095, 12'd0, 12'd4095, 12'd0,
                            12'd4095, 12'd4095};
            2: settings = '{1'b1, 2'd1, 12'd2000, 12'd2000, 12'd0, 12'd4095,
                            12'd4095, 12'd0};
            3: settings = '{1'b1, 2'd2, 12'd1, 12'd0, 12'($urandom), 12'($urandom),
                            12'd4095, 12'($urandom)};
            4: settings = '{1'($urandom), 2'($urandom), 12'($urandom), 12'($urandom),
                            12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)};
            default: settings = '{1'b1, 2'($urandom), 12'($urandom), 12'($urandom),
                                  12'($urandom), 12'($urandom), 12'($urandom),
                                  12'($urandom)};
         endcase
         load_settings(settings);
         if (phase < 2) begin
            send_idle_pct = 35;
            recv_idle_pct = 77;
         end else if (phase < 4) begin
            send_idle_pct = 77;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // long receiver hold-off so the block backs up into the request side
         if (phase == 1 || phase == 4) holdoff_request = 600;
         items_sent = 0;
         paused = 1'b0;
         while (items_sent < 242) begin
            send_stroke();
            if (phase == 3 && !paused && items_sent > 120) begin
               drain(0);
               paused = 1'b1;
            end
         end
      end

      drain(150);
      if (touch_sb.fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
